// File: rtl/assert_macros.svh
// assertion macros used by the rtl mapper core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bsm_pkg.sv
// shared types and codes for the bank switch mapper
`default_nettype none

package bsm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MOD  = 2'b10
  } state_t;

  localparam logic [2:0] ACT_CPU_RD = 3'd0;
  localparam logic [2:0] ACT_CPU_WR = 3'd1;
  localparam logic [2:0] ACT_PPU_RD = 3'd2;
  localparam logic [2:0] ACT_PPU_WR = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [2:0] RGN_PRG_ROM  = 3'd0;
  localparam logic [2:0] RGN_PRG_RAM  = 3'd1;
  localparam logic [2:0] RGN_CHR_ROM  = 3'd2;
  localparam logic [2:0] RGN_CHR_RAM  = 3'd3;
  localparam logic [2:0] RGN_REG_WR   = 3'd4;
  localparam logic [2:0] RGN_UNMAPPED = 3'd5;
  localparam logic [2:0] RGN_TICK     = 3'd6;

  localparam logic [1:0] CFG_PRG_UNITS = 2'd0;
  localparam logic [1:0] CFG_CHR_UNITS = 2'd1;

  localparam logic [7:0] CHR_PAIR_MASK = 8'hFE;

endpackage

`default_nettype wire

// File: rtl/bank_switch_mapper_with_scanline_irq_core.sv
// every action gives a registered result in the cycle after it is accepted.
// a bank register write (or a size register write) starts a serial remainder unit,
// one bit per cycle: one bank after a bank write, all eight banks after a size write.
// throughput: 1 item per cycle unless results stall or the remainder unit is busy.
// reset (synchronous, rst high): all mapper registers zero, sizes 2 and 1, idle.
`default_nettype none
`include "assert_macros.svh"

module bank_switch_mapper_with_scanline_irq_core import bsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  region,
  output logic [21:0] byte_offset,
  output logic        irq_request,
  output logic        mirroring,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  state_t      state;
  logic [7:0]  prg_units;
  logic [7:0]  chr_units;
  logic [2:0]  bank_select;
  logic        prg_mode;
  logic        chr_mode;
  logic [7:0]  bank_regs [8];
  logic [7:0]  red [8];   // bank numbers already reduced by the bank count
  logic [7:0]  irq_latch;
  logic [7:0]  irq_counter;
  logic        irq_enable;
  logic        irq_reload;
  logic        mirror_flag;
  logic [2:0]  idx;
  logic [2:0]  bit_cnt;
  logic [7:0]  rem;
  logic        sweep;

  logic        accept;
  logic        is_cpu;
  logic        is_ppu;
  logic        reg_wr;
  logic        odd;
  logic        cfg_hit;
  logic [13:0] pa;
  logic [7:0]  counter_next;
  logic        mirror_next;
  logic [2:0]  res_region;
  logic [21:0] res_offset;
  logic        res_irq;
  logic [8:0]  prg_bank;
  logic [8:0]  prg_second;
  logic [8:0]  prg_last;
  logic [2:0]  chr_slot;
  logic [2:0]  chr_idx;
  logic [7:0]  chr_bank;

  // shared remainder unit
  logic [7:0]  dividend;
  logic [10:0] divisor;
  logic [8:0]  trial;
  logic [10:0] diff;
  logic [7:0]  rem_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign is_cpu   = (action == ACT_CPU_RD) || (action == ACT_CPU_WR);
  assign is_ppu   = (action == ACT_PPU_RD) || (action == ACT_PPU_WR);
  assign reg_wr   = (action == ACT_CPU_WR) && bus_address[15];
  assign odd      = bus_address[0];
  assign pa       = bus_address[13:0];
  assign cfg_hit  = cfg_we && ((cfg_index == CFG_PRG_UNITS) || (cfg_index == CFG_CHR_UNITS));

  assign counter_next = ((irq_counter == 8'd0) || irq_reload) ? irq_latch
                                                              : irq_counter - 8'd1;
  assign mirror_next  = (reg_wr && bus_address[14:13] == 2'b01 && !odd) ? ~write_data[0]
                                                                        : mirror_flag;

  // program banks in 8 KiB units
  assign prg_second = {prg_units, 1'b0} - 9'd2;
  assign prg_last   = {prg_units, 1'b0} - 9'd1;

  always_comb begin
    prg_bank = 9'd0;
    if (prg_units != 8'd0) begin
      unique case (bus_address[14:13])
        2'b00:   prg_bank = prg_mode ? prg_second : {1'b0, red[6]};
        2'b01:   prg_bank = {1'b0, red[7]};
        2'b10:   prg_bank = prg_mode ? {1'b0, red[6]} : prg_second;
        default: prg_bank = prg_last;
      endcase
    end
  end

  // character slots: mode swaps the 2 KiB pair half with the 1 KiB half
  assign chr_slot = pa[12:10] ^ {chr_mode, 2'b00};
  assign chr_idx  = chr_slot[2] ? ({1'b0, chr_slot[1:0]} + 3'd2) : {2'b00, chr_slot[1]};
  assign chr_bank = chr_slot[2] ? red[chr_idx] : (red[chr_idx] | {7'd0, chr_slot[0]});

  always_comb begin
    res_region = RGN_UNMAPPED;
    res_offset = 22'd0;
    res_irq    = 1'b0;
    if (is_cpu) begin
      if (bus_address[15:13] == 3'b011) begin
        res_region = RGN_PRG_RAM;
        res_offset = {9'd0, bus_address[12:0]};
      end else if (bus_address[15]) begin
        if (action == ACT_CPU_WR) begin
          res_region = RGN_REG_WR;
        end else begin
          res_region = RGN_PRG_ROM;
          res_offset = {prg_bank, bus_address[12:0]};
        end
      end
    end else if (is_ppu) begin
      if (!pa[13]) begin
        if (chr_units == 8'd0) begin
          res_region = RGN_CHR_RAM;
          res_offset = {9'd0, pa[12:0]};
        end else if (action == ACT_PPU_RD) begin
          res_region = RGN_CHR_ROM;
          res_offset = {4'd0, chr_bank, pa[9:0]};
        end
      end
    end else if (action == ACT_TICK) begin
      res_region = RGN_TICK;
      res_irq    = (counter_next == 8'd0) && irq_enable;
    end
  end

  // one restoring step per cycle, msb first
  assign dividend = (idx[2:1] == 2'b00) ? (bank_regs[idx] & CHR_PAIR_MASK) : bank_regs[idx];
  assign divisor  = (idx[2:1] == 2'b11) ? {2'b00, prg_units, 1'b0} : {chr_units, 3'b000};
  assign trial    = {rem, dividend[bit_cnt]};
  assign diff     = {2'b00, trial} - divisor;
  assign rem_next = ({2'b00, trial} >= divisor) ? diff[7:0] : trial[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prg_units   <= 8'd2;
      chr_units   <= 8'd1;
      bank_select <= 3'd0;
      prg_mode    <= 1'b0;
      chr_mode    <= 1'b0;
      irq_latch   <= 8'd0;
      irq_counter <= 8'd0;
      irq_enable  <= 1'b0;
      irq_reload  <= 1'b0;
      mirror_flag <= 1'b0;
      idx         <= 3'd0;
      bit_cnt     <= 3'd7;
      rem         <= 8'd0;
      sweep       <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_regs[i] <= 8'd0;
        red[i]       <= 8'd0;
      end
    end else begin
      if (accept) begin
        out_valid   <= 1'b1;
        mirror_flag <= mirror_next;
        if (action == ACT_TICK) begin
          irq_counter <= counter_next;
          irq_reload  <= 1'b0;
        end
        if (reg_wr) begin
          unique case (bus_address[14:13])
            2'b00: begin
              if (!odd) begin
                bank_select <= write_data[2:0];
                prg_mode    <= write_data[6];
                chr_mode    <= write_data[7];
              end else begin
                bank_regs[bank_select] <= write_data;
                idx     <= bank_select;
                bit_cnt <= 3'd7;
                rem     <= 8'd0;
                sweep   <= 1'b0;
                state   <= ST_MOD;
              end
            end
            2'b01: begin
            end
            2'b10: begin
              if (!odd) irq_latch <= write_data;
              else irq_reload <= 1'b1;
            end
            default: begin
              irq_enable <= odd;
            end
          endcase
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (state == ST_MOD) begin
        if (bit_cnt == 3'd0) begin
          red[idx] <= rem_next;
          rem      <= 8'd0;
          bit_cnt  <= 3'd7;
          if (sweep && idx != 3'd7) begin
            idx <= idx + 3'd1;
          end else begin
            sweep <= 1'b0;
            state <= ST_IDLE;
          end
        end else begin
          rem     <= rem_next;
          bit_cnt <= bit_cnt - 3'd1;
        end
      end

      // size change: reduce all eight banks again
      if (cfg_hit) begin
        if (cfg_index == CFG_PRG_UNITS) prg_units <= cfg_data;
        else chr_units <= cfg_data;
        state   <= ST_MOD;
        sweep   <= 1'b1;
        idx     <= 3'd0;
        bit_cnt <= 3'd7;
        rem     <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      region      <= res_region;
      byte_offset <= res_offset;
      irq_request <= res_irq;
      mirroring   <= mirror_next;
    end
  end

  `ASSERT_IMP(a_busy_not_ready, state == ST_MOD, !in_ready, "ready while remainder unit busy")
  `ASSERT_NXT(a_bank_wr_starts,
              accept && reg_wr && bus_address[14:13] == 2'b00 && odd,
              state == ST_MOD && idx == $past(bank_select),
              "bank write did not start reduction")
  `ASSERT_NXT(a_tick_result, accept && action == ACT_TICK,
              out_valid && region == RGN_TICK && byte_offset == 22'd0,
              "tick transaction gave wrong result")
  `ASSERT_IMP(a_sweep_only_busy, sweep, state == ST_MOD, "sweep flag set while idle")

endmodule

`default_nettype wire

// File: bench/bank_switch_mapper_with_scanline_irq_core_tb.sv
// self-checking testbench for the bank switch mapper core
`default_nettype none

module bank_switch_mapper_with_scanline_irq_core_tb;
  import bsm_pkg::*;

  localparam int unsigned PRG_BANK_BYTES = 8192;
  localparam int unsigned CHR_BANK_BYTES = 1024;
  localparam logic [2:0]  ACT_RSVD_5     = 3'd5;
  localparam logic [2:0]  ACT_RSVD_7     = 3'd7;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned PHASE_ITEMS    = 155;
  localparam int unsigned NUM_PHASES     = 6;

  typedef struct packed {
    logic [2:0]  region;
    logic [21:0] byte_offset;
    logic        irq_request;
    logic        mirroring;
  } mapper_result_t;

  typedef struct packed {
    logic [2:0]     act;
    logic [15:0]    adr;
    logic [7:0]     dat;
    logic           fixed;
    mapper_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  region;
  logic [21:0] byte_offset;
  logic        irq_request;
  logic        mirroring;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // expectation typed into the directed table travels with the payload
  logic           stim_fixed;
  mapper_result_t stim_fixed_res;

  bank_switch_mapper_with_scanline_irq_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .bus_address (bus_address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .region      (region),
    .byte_offset (byte_offset),
    .irq_request (irq_request),
    .mirroring   (mirroring),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // mapper state mirrored in the bench
  int unsigned m_prg_units;
  int unsigned m_chr_units;
  logic [2:0]  m_sel;
  logic        m_prg_mode;
  logic        m_chr_mode;
  logic [7:0]  m_banks [8];
  logic [21:0] m_prg_base [4];
  logic [20:0] m_chr_base [8];
  logic [7:0]  m_latch;
  logic [7:0]  m_counter;
  logic        m_irq_en;
  logic        m_reload;
  logic        m_mirror;

  mapper_result_t pending_results [$];
  stim_row_t      dir_rows [$];

  int unsigned n_mismatch;
  int unsigned n_checked;
  int unsigned n_irq;
  int unsigned n_region [8];
  logic        quiet_in;
  logic        quiet_out;
  logic        squeeze;

  function automatic void rebuild_bank_bases();
    int unsigned prg_banks, chr_banks, last, second, b6, b7, lo, hi;
    int unsigned c [6];
    prg_banks = m_prg_units * 2;
    chr_banks = m_chr_units * 8;
    if (chr_banks == 0) chr_banks = 8;
    last = 0;
    second = 0;
    b6 = 0;
    b7 = 0;
    if (prg_banks > 0) begin
      last = (prg_banks - 1) * PRG_BANK_BYTES;
      b6 = (m_banks[6] % prg_banks) * PRG_BANK_BYTES;
      b7 = (m_banks[7] % prg_banks) * PRG_BANK_BYTES;
    end
    if (prg_banks > 1) second = (prg_banks - 2) * PRG_BANK_BYTES;
    m_prg_base[0] = 22'(m_prg_mode ? second : b6);
    m_prg_base[1] = 22'(b7);
    m_prg_base[2] = 22'(m_prg_mode ? b6 : second);
    m_prg_base[3] = 22'(last);
    // the first two registers pick 2 KiB pairs, so their low bit is dropped
    for (int i = 0; i < 6; i++) begin
      c[i] = ((i < 2 ? (m_banks[i] & CHR_PAIR_MASK) : m_banks[i]) % chr_banks)
             * CHR_BANK_BYTES;
    end
    lo = m_chr_mode ? 4 : 0;
    hi = m_chr_mode ? 0 : 4;
    m_chr_base[lo]     = 21'(c[0]);
    m_chr_base[lo + 1] = 21'(c[0] + CHR_BANK_BYTES);
    m_chr_base[lo + 2] = 21'(c[1]);
    m_chr_base[lo + 3] = 21'(c[1] + CHR_BANK_BYTES);
    m_chr_base[hi]     = 21'(c[2]);
    m_chr_base[hi + 1] = 21'(c[3]);
    m_chr_base[hi + 2] = 21'(c[4]);
    m_chr_base[hi + 3] = 21'(c[5]);
  endfunction

  function automatic mapper_result_t map_access(input logic [2:0] a, input logic [15:0] adr,
                                                input logic [7:0] d);
    mapper_result_t r;
    r = '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0};
    case (a)
      ACT_CPU_RD, ACT_CPU_WR: begin
        if (adr >= 16'h6000 && adr <= 16'h7FFF) begin
          r.region = RGN_PRG_RAM;
          r.byte_offset = {9'd0, adr[12:0]};
        end else if (adr[15]) begin
          if (a == ACT_CPU_WR) begin
            r.region = RGN_REG_WR;
            case (adr[14:13])
              2'd0: begin
                if (!adr[0]) begin
                  m_sel = d[2:0];
                  m_prg_mode = d[6];
                  m_chr_mode = d[7];
                end else begin
                  m_banks[m_sel] = d;
                end
                rebuild_bank_bases();
              end
              2'd1: if (!adr[0]) m_mirror = ~d[0];
              2'd2: begin
                if (!adr[0]) m_latch = d;
                else m_reload = 1'b1;
              end
              default: m_irq_en = adr[0];
            endcase
          end else begin
            r.region = RGN_PRG_ROM;
            r.byte_offset = m_prg_base[adr[14:13]] + {9'd0, adr[12:0]};
          end
        end
      end
      ACT_PPU_RD, ACT_PPU_WR: begin
        // pattern tables only; the upper half of the 16 KiB space is nametables
        if (!adr[13]) begin
          if (m_chr_units == 0) begin
            r.region = RGN_CHR_RAM;
            r.byte_offset = {9'd0, adr[12:0]};
          end else if (a == ACT_PPU_RD) begin
            r.region = RGN_CHR_ROM;
            r.byte_offset = {1'b0, m_chr_base[adr[12:10]]} + {12'd0, adr[9:0]};
          end
        end
      end
      ACT_TICK: begin
        if (m_counter == 8'd0 || m_reload) begin
          m_counter = m_latch;
          m_reload = 1'b0;
        end else begin
          m_counter = m_counter - 8'd1;
        end
        r.region = RGN_TICK;
        r.irq_request = (m_counter == 8'd0) && m_irq_en;
      end
      default: ;
    endcase
    r.mirroring = m_mirror;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("bank_switch_mapper_with_scanline_irq_core_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin : monitor
    mapper_result_t got;
    mapper_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{region, byte_offset, irq_request, mirroring};
        n_checked++;
        n_region[got.region]++;
        if (got.irq_request === 1'b1) n_irq++;
        if (pending_results.size() == 0) begin
          if (n_mismatch < 10)
            $display("unexpected transaction: region %0d offset %h irq %b mirror %b",
                     got.region, got.byte_offset, got.irq_request, got.mirroring);
          n_mismatch++;
        end else begin
          want = pending_results.pop_front();
          if (got.region !== want.region || got.byte_offset !== want.byte_offset ||
              got.irq_request !== want.irq_request || got.mirroring !== want.mirroring) begin
            if (n_mismatch < 10)
              $display("mismatch: exp region %0d offset %h irq %b mirror %b, got %0d %h %b %b",
                       want.region, want.byte_offset, want.irq_request, want.mirroring,
                       got.region, got.byte_offset, got.irq_request, got.mirroring);
            n_mismatch++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = map_access(action, bus_address, write_data);
        pending_results.push_back(stim_fixed ? stim_fixed_res : want);
      end
    end
  end

  // result side: random stalls, runs of none, and one long hold-off
  initial begin : receiver
    int unsigned hold;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
      hold = quiet_out ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  task automatic offer(input logic [2:0] a, input logic [15:0] adr, input logic [7:0] d,
                       input logic fixed, input mapper_result_t fixed_res);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    bus_address <= adr;
    write_data <= d;
    stim_fixed <= fixed;
    stim_fixed_res <= fixed_res;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // let every transaction drain, then give the serial remainder time to finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [1:0] idx, input logic [7:0] val);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRG_UNITS) m_prg_units = 32'(val);
    else m_chr_units = 32'(val);
    rebuild_bank_bases();
  endtask

  initial begin : stimulus
    logic [2:0]  a;
    logic [15:0] adr;
    logic [7:0]  d;
    logic [7:0]  prg_set;
    logic [7:0]  chr_set;
    int unsigned pick;
    mapper_result_t none;

    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_CPU_RD;
    bus_address = 16'h0000;
    write_data = 8'h00;
    cfg_we = 1'b0;
    cfg_index = CFG_PRG_UNITS;
    cfg_data = 8'h00;
    stim_fixed = 1'b0;
    stim_fixed_res = '0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    squeeze = 1'b0;
    n_mismatch = 0;
    n_checked = 0;
    n_irq = 0;
    foreach (n_region[k]) n_region[k] = 0;

    m_prg_units = 2;
    m_chr_units = 1;
    m_sel = 3'd0;
    m_prg_mode = 1'b0;
    m_chr_mode = 1'b0;
    foreach (m_banks[k]) m_banks[k] = 8'h00;
    m_latch = 8'h00;
    m_counter = 8'h00;
    m_irq_en = 1'b0;
    m_reload = 1'b0;
    m_mirror = 1'b0;
    rebuild_bank_bases();

    // reset sizes: 4 program banks, 8 character banks
    dir_rows.push_back('{ACT_CPU_RD, 16'h0000, 8'h00, 1'b1, '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_WR, 16'h5FFF, 8'hFF, 1'b1, '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_RD, 16'h6000, 8'h00, 1'b1, '{RGN_PRG_RAM, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_WR, 16'h7FFF, 8'hFF, 1'b1,
                         '{RGN_PRG_RAM, 22'h1FFF, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_RD, 16'h8000, 8'h00, 1'b1, '{RGN_PRG_ROM, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_RD, 16'hC000, 8'h00, 1'b1,
                         '{RGN_PRG_ROM, 22'h4000, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_RD, 16'hFFFF, 8'h00, 1'b1,
                         '{RGN_PRG_ROM, 22'h7FFF, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_PPU_RD, 16'h0000, 8'h00, 1'b1, '{RGN_CHR_ROM, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_PPU_RD, 16'h3FFF, 8'h00, 1'b1, '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_PPU_WR, 16'h0000, 8'hA5, 1'b1, '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_RSVD_5, 16'h8000, 8'h00, 1'b1, '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_RSVD_7, 16'hFFFF, 8'hFF, 1'b1, '{RGN_UNMAPPED, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_TICK,   16'h0000, 8'h00, 1'b1, '{RGN_TICK, 22'd0, 1'b0, 1'b0}});
    dir_rows.push_back('{ACT_CPU_WR, 16'hA000, 8'h00, 1'b1, '{RGN_REG_WR, 22'd0, 1'b0, 1'b1}});
    dir_rows.push_back('{ACT_CPU_WR, 16'h8000, 8'hC6, 1'b1, '{RGN_REG_WR, 22'd0, 1'b0, 1'b1}});
    // from here on the predictor supplies the expectation
    dir_rows.push_back('{ACT_CPU_WR, 16'h8001, 8'hFF, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_RD, 16'h8000, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_RD, 16'hC123, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_PPU_RD, 16'h1C00, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'h8000, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'h8001, 8'h03, 1'b0, none});
    dir_rows.push_back('{ACT_PPU_RD, 16'h07FF, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'hC000, 8'h02, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'hC001, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'hE001, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_TICK,   16'hFFFF, 8'hFF, 1'b0, none});
    dir_rows.push_back('{ACT_TICK,   16'h0000, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_TICK,   16'h0000, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'hE000, 8'h00, 1'b0, none});
    dir_rows.push_back('{ACT_CPU_WR, 16'hA001, 8'h00, 1'b0, none});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      offer(dir_rows[k].act, dir_rows[k].adr, dir_rows[k].dat, dir_rows[k].fixed,
            dir_rows[k].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin prg_set = 8'd0;   chr_set = 8'd0;   end
        1: begin prg_set = 8'd255; chr_set = 8'd255; end
        2: begin prg_set = 8'd1;   chr_set = 8'd0;   end
        3: begin prg_set = 8'd3;   chr_set = 8'd2;   end
        default: begin
          prg_set = 8'($urandom_range(1, 255));
          chr_set = 8'($urandom_range(1, 255));
        end
      endcase
      set_size(CFG_PRG_UNITS, prg_set);
      set_size(CFG_CHR_UNITS, chr_set);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) squeeze = 1'b1;
        adr = 16'($urandom);
        d = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          a = ACT_CPU_RD;
          adr[15] = 1'b1;
        end else if (pick < 30) begin
          a = ACT_CPU_RD;
        end else if (pick < 50) begin
          a = ACT_CPU_WR;
          adr[15] = 1'b1;
          // small latch values so the counter runs out often
          if (adr[14:13] == 2'd2 && !adr[0] && $urandom_range(0, 2) != 0)
            d = 8'($urandom_range(0, 3));
        end else if (pick < 55) begin
          a = ACT_CPU_WR;
        end else if (pick < 72) begin
          a = ACT_PPU_RD;
          if ($urandom_range(0, 1) == 0) adr[13] = 1'b0;
        end else if (pick < 78) begin
          a = ACT_PPU_WR;
        end else if (pick < 95) begin
          a = ACT_TICK;
        end else begin
          a = 3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
        end
        offer(a, adr, d, 1'b0, none);
      end
    end

    settle();
    $display("%0d transactions checked under %0d size settings, %0d mismatches",
             n_checked, NUM_PHASES + 1, n_mismatch);
    $display("irq raised %0d times; prg rom %0d, chr rom %0d, chr ram %0d, register %0d",
             n_irq, n_region[RGN_PRG_ROM], n_region[RGN_CHR_ROM], n_region[RGN_CHR_RAM],
             n_region[RGN_REG_WR]);
    if (n_mismatch == 0 && pending_results.size() == 0)
      $display("bank_switch_mapper_with_scanline_irq_core_tb: PASS");
    else
      $display("bank_switch_mapper_with_scanline_irq_core_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/bsm_pkg.sv
rtl/bank_switch_mapper_with_scanline_irq_core.sv
bench/bank_switch_mapper_with_scanline_irq_core_tb.sv
